// ===== src/assert_macros.svh =====
// Assertion macros shared by the history ring RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/thrr_pkg.sv =====
// Types and constants of the timestamped history ring.
`default_nettype none
package thrr_pkg;

  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StampW = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned SlotW  = 5;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH      = 3'd0,
    KIND_REWIND    = 3'd1,
    KIND_READ_CUR  = 3'd2,
    KIND_READ_OLD  = 3'd3,
    KIND_OVERWRITE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StampW-1:0] stamp;
    logic [DataW-1:0]  payload;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [StampW-1:0] entry_stamp;
    logic [DataW-1:0]  entry_data;
    logic [SlotW-1:0]  slot;
  } out_item_t;

endpackage
`default_nettype wire

// ===== src/thrr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module thrr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/timestamped_history_ring_rewind.sv =====
// Top level of the timestamped history ring with time rewind.
// Push and overwrite register the result directly; reads add the registered RAM read.
// Rewind: one RAM read and one stamp compare per slot walked, then the result read.
// One item at a time; the next transfer waits until idle and no result is stalled.
// Reset clears the pointers, the written marks and the control; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module timestamped_history_ring_rewind #(
  parameter int unsigned DEPTH = thrr_pkg::DefaultDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire thrr_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output thrr_pkg::out_item_t      out_item_o
);
  import thrr_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned EntW = StampW + DataW;

  typedef logic [PtrW-1:0] ptr_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? ptr_t'(DEPTH - 1) : p - ptr_t'(1);
  endfunction

  // Slots above zero are written in order, so a high mark covers them.
  function automatic logic is_written(ptr_t p, logic z, ptr_t hw);
    return (p == '0) ? z : (p <= hw);
  endfunction

  state_e    state_q, state_d;
  ptr_t      newest_q, newest_d;
  ptr_t      oldest_q, oldest_d;
  ptr_t      hw_q, hw_d;
  logic      zero_wr_q, zero_wr_d;
  ptr_t      pos_q, pos_d;
  ptr_t      rd_addr_q, rd_addr_d;
  logic      found_q, found_d;
  logic [StampW-1:0] target_q, target_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic      in_acc;
  logic      out_load;
  ptr_t      push_slot;
  ptr_t      pos_prev;
  logic      pos_written;
  logic      rd_written;

  logic              ram_we;
  ptr_t              ram_waddr;
  logic [EntW-1:0]   ram_wdata;
  logic              ram_re;
  ptr_t              ram_raddr;
  logic [EntW-1:0]   ram_rdata;
  logic [StampW-1:0] ram_stamp;
  logic [DataW-1:0]  ram_data;

  thrr_ram #(
    .WIDTH(EntW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_stamp   = ram_rdata[EntW-1:DataW];
  assign ram_data    = ram_rdata[DataW-1:0];
  assign ram_wdata   = {in_item_i.stamp, in_item_i.payload};
  assign push_slot   = ptr_inc(newest_q);
  assign pos_prev    = ptr_dec(pos_q);
  assign pos_written = is_written(pos_q, zero_wr_q, hw_q);
  assign rd_written  = is_written(rd_addr_q, zero_wr_q, hw_q);

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      newest_q    <= '0;
      oldest_q    <= '0;
      hw_q        <= '0;
      zero_wr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      hw_q        <= hw_d;
      zero_wr_q   <= zero_wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    rd_addr_q  <= rd_addr_d;
    found_q    <= found_d;
    target_q   <= target_d;
    out_item_q <= out_item_d;
  end

  always_comb begin
    state_d    = state_q;
    newest_d   = newest_q;
    oldest_d   = oldest_q;
    hw_d       = hw_q;
    zero_wr_d  = zero_wr_q;
    pos_d      = pos_q;
    rd_addr_d  = rd_addr_q;
    found_d    = found_q;
    target_d   = target_q;
    out_item_d = out_item_q;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = newest_q;
    ram_re     = 1'b0;
    ram_raddr  = newest_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          target_d = in_item_i.stamp;
          unique case (in_item_i.kind)
            KIND_PUSH: begin
              ram_we    = 1'b1;
              ram_waddr = push_slot;
              newest_d  = push_slot;
              if (push_slot == oldest_q) begin
                oldest_d = ptr_inc(oldest_q);
              end
              out_load               = 1'b1;
              out_item_d.found       = 1'b1;
              out_item_d.entry_stamp = in_item_i.stamp;
              out_item_d.entry_data  = in_item_i.payload;
              out_item_d.slot        = SlotW'(push_slot);
            end
            KIND_OVERWRITE: begin
              ram_we                 = 1'b1;
              ram_waddr              = newest_q;
              out_load               = 1'b1;
              out_item_d.found       = 1'b1;
              out_item_d.entry_stamp = in_item_i.stamp;
              out_item_d.entry_data  = in_item_i.payload;
              out_item_d.slot        = SlotW'(newest_q);
            end
            KIND_REWIND: begin
              ram_re    = 1'b1;
              ram_raddr = newest_q;
              pos_d     = newest_q;
              state_d   = ST_WALK;
            end
            KIND_READ_OLD: begin
              ram_re    = 1'b1;
              ram_raddr = oldest_q;
              rd_addr_d = oldest_q;
              found_d   = is_written(oldest_q, zero_wr_q, hw_q);
              state_d   = ST_READ;
            end
            default: begin
              ram_re    = 1'b1;
              ram_raddr = newest_q;
              rd_addr_d = newest_q;
              found_d   = is_written(newest_q, zero_wr_q, hw_q);
              state_d   = ST_READ;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!pos_written || (ram_stamp > target_q && pos_prev == newest_q)) begin
          // fail: report the unchanged head
          found_d   = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = newest_q;
          rd_addr_d = newest_q;
          state_d   = ST_READ;
        end else if (ram_stamp <= target_q) begin
          newest_d  = pos_q;
          oldest_d  = ptr_inc(pos_q);
          found_d   = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = pos_q;
          rd_addr_d = pos_q;
          state_d   = ST_READ;
        end else begin
          pos_d     = pos_prev;
          ram_re    = 1'b1;
          ram_raddr = pos_prev;
        end
      end
      ST_READ: begin
        out_load               = 1'b1;
        out_item_d.found       = found_q;
        out_item_d.entry_stamp = rd_written ? ram_stamp : '0;
        out_item_d.entry_data  = rd_written ? ram_data : '0;
        out_item_d.slot        = SlotW'(rd_addr_q);
        state_d                = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // mark the slot written
    if (ram_we) begin
      if (ram_waddr == '0) begin
        zero_wr_d = 1'b1;
      end else if (ram_waddr > hw_q) begin
        hw_d = ram_waddr;
      end
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  `ASSERT_IMPLIES(a_walk_no_result, state_q == ST_WALK, !out_valid_q)
  `ASSERT_ALWAYS(a_ptr_range, (32'(newest_q) < DEPTH) && (32'(oldest_q) < DEPTH))
  `ASSERT_NEXT(a_push_advance, in_acc && in_item_i.kind == KIND_PUSH, newest_q == $past(push_slot))
  `ASSERT_NEXT(a_head_written, ram_we, is_written(newest_q, zero_wr_q, hw_q))
  `ASSERT_IMPLIES(a_result_source, $rose(out_valid_q), $past(state_q == ST_READ || in_acc))

endmodule
`default_nettype wire

// ===== bench/thrr_ring_scoreboard.sv =====
// Scoreboard for the history ring: predicts each accepted transfer and checks every result.
module thrr_ring_scoreboard (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  thrr_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  thrr_pkg::out_item_t out_item_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import thrr_pkg::*;

  logic [StampW-1:0] ring_stamp   [DefaultDepth];
  logic [DataW-1:0]  ring_data    [DefaultDepth];
  logic              ring_written [DefaultDepth];
  logic [SlotW-1:0]  newest_slot;
  logic [SlotW-1:0]  oldest_slot;
  out_item_t         expected_entries [$];
  int                mismatches;

  function automatic out_item_t describe_slot(logic [SlotW-1:0] pos, logic ok);
    out_item_t entry;
    entry.found       = ok;
    entry.entry_stamp = ring_written[pos] ? ring_stamp[pos] : '0;
    entry.entry_data  = ring_written[pos] ? ring_data[pos] : '0;
    entry.slot        = pos;
    return entry;
  endfunction

  function automatic void store_entry(logic [SlotW-1:0] pos, logic [StampW-1:0] stamp,
                                      logic [DataW-1:0] data);
    ring_stamp[pos]   = stamp;
    ring_data[pos]    = data;
    ring_written[pos] = 1'b1;
  endfunction

  function automatic out_item_t apply_history_op(in_item_t op);
    logic [SlotW-1:0] pos;
    logic             hit;
    int               k;
    out_item_t        entry;
    case (op.kind)
      KIND_PUSH: begin
        newest_slot = newest_slot + 1'b1;
        store_entry(newest_slot, op.stamp, op.payload);
        if (newest_slot == oldest_slot) oldest_slot = oldest_slot + 1'b1;
        entry = describe_slot(newest_slot, 1'b1);
      end
      KIND_REWIND: begin
        pos = newest_slot;
        hit = 1'b0;
        for (k = 0; k < DefaultDepth; k++) begin
          if (!ring_written[pos]) break;
          if (ring_stamp[pos] <= op.stamp) begin
            hit = 1'b1;
            break;
          end
          pos = pos - 1'b1;
          if (pos == newest_slot) break;
        end
        if (hit) begin
          newest_slot = pos;
          oldest_slot = pos + 1'b1;
        end
        entry = describe_slot(newest_slot, hit);
      end
      KIND_READ_OLD: entry = describe_slot(oldest_slot, ring_written[oldest_slot]);
      KIND_OVERWRITE: begin
        store_entry(newest_slot, op.stamp, op.payload);
        entry = describe_slot(newest_slot, 1'b1);
      end
      default: entry = describe_slot(newest_slot, ring_written[newest_slot]);
    endcase
    return entry;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int        i;
    if (!rst_ni) begin
      for (i = 0; i < DefaultDepth; i++) ring_written[i] = 1'b0;
      newest_slot = '0;
      oldest_slot = '0;
      expected_entries.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t history ring: unexpected result found=%0b stamp=%h data=%h slot=%0d",
                     $realtime, out_item_i.found, out_item_i.entry_stamp,
                     out_item_i.entry_data, out_item_i.slot);
        end else begin
          want = expected_entries.pop_front();
          if (out_item_i.found !== want.found || out_item_i.entry_stamp !== want.entry_stamp ||
              out_item_i.entry_data !== want.entry_data || out_item_i.slot !== want.slot) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t history ring mismatch: expected found=%0b stamp=%h data=%h ",
                        "slot=%0d, got found=%0b stamp=%h data=%h slot=%0d"},
                       $realtime, want.found, want.entry_stamp, want.entry_data, want.slot,
                       out_item_i.found, out_item_i.entry_stamp, out_item_i.entry_data,
                       out_item_i.slot);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_entries.push_back(apply_history_op(in_item_i));
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_entries.size();
  end

endmodule

// ===== bench/tb_timestamped_history_ring_rewind.sv =====
// Testbench top for the timestamped history ring: stimulus, handshake pacing and verdict.
module tb_timestamped_history_ring_rewind;
  timeunit 1ns;
  timeprecision 1ps;
  import thrr_pkg::*;

  localparam logic [KindW-1:0] KIND_SPARE_FIRST = KIND_OVERWRITE + 1'b1;
  localparam logic [KindW-1:0] KIND_SPARE_LAST  = {KindW{1'b1}};
  localparam int unsigned      RANDOM_OPS       = 1050;
  localparam int unsigned      HOLD_CYCLES      = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  int          mismatch_count;
  int          pending_count;
  int unsigned idle_phase = 0;
  int unsigned sent_count = 0;
  in_item_t    ring_ops [$];

  timestamped_history_ring_rewind dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  thrr_ring_scoreboard u_scoreboard (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  function automatic void add_op(logic [KindW-1:0] kind, logic [StampW-1:0] stamp,
                                 logic [DataW-1:0] payload);
    in_item_t op;
    op.kind    = kind;
    op.stamp   = stamp;
    op.payload = payload;
    ring_ops.push_back(op);
  endfunction

  function automatic void add_random_history(int unsigned target_count);
    logic [StampW-1:0] now_tick;
    logic [StampW-1:0] base;
    int unsigned       roll;
    int unsigned       pick;
    int unsigned       n;
    int unsigned       j;
    now_tick = $urandom;
    while (ring_ops.size() < target_count) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        // fill the whole ring, then rewind below every stamp so the walk wraps
        base = now_tick;
        n = $urandom_range(DefaultDepth, DefaultDepth + 8);
        for (j = 0; j < n; j++) begin
          now_tick += $urandom_range(1, 64);
          add_op(KIND_PUSH, now_tick, $urandom);
        end
        add_op(KIND_REWIND, base, $urandom);
        add_op(KIND_READ_OLD, $urandom, $urandom);
      end else if (roll < 85) begin
        n = $urandom_range(5, 15);
        for (j = 0; j < n; j++) begin
          pick = $urandom_range(99);
          if (pick < 45) begin
            now_tick += $urandom_range(1, 64);
            add_op(KIND_PUSH, now_tick, $urandom);
          end else if (pick < 65) begin
            now_tick -= $urandom_range(0, 1500);
            add_op(KIND_REWIND, now_tick, $urandom);
          end else if (pick < 75) begin
            add_op(KIND_READ_CUR, $urandom, $urandom);
          end else if (pick < 85) begin
            add_op(KIND_READ_OLD, $urandom, $urandom);
          end else begin
            add_op(KIND_OVERWRITE, now_tick + $urandom_range(0, 8), $urandom);
          end
        end
      end else begin
        n = $urandom_range(1, 4);
        for (j = 0; j < n; j++) begin
          add_op(KindW'($urandom_range(0, KIND_SPARE_LAST)), $urandom, $urandom);
        end
      end
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("[timestamped_history_ring_rewind] ERROR");
    $finish;
  end

  initial begin
    int unsigned     i;
    int unsigned     phase;
    int unsigned     idle_pct;
    logic [KindW-1:0] k;
    in_valid <= 1'b0;
    in_item  <= '0;

    add_op(KIND_READ_CUR, '0, '0);
    add_op(KIND_READ_OLD, '0, '0);
    add_op(KIND_REWIND, '1, '0);
    add_op(KIND_OVERWRITE, '0, '0);
    add_op(KIND_READ_OLD, '1, '1);
    add_op(KIND_PUSH, 32'd100, '1);
    add_op(KIND_PUSH, 32'd200, 32'ha5a5_a5a5);
    add_op(KIND_PUSH, '1, 32'h5a5a_5a5a);
    add_op(KIND_REWIND, 32'd250, '0);
    add_op(KIND_READ_OLD, '0, '0);
    add_op(KIND_REWIND, '0, '0);
    add_op(KIND_OVERWRITE, 32'd50, 32'h1234_5678);
    add_op(KIND_REWIND, 32'd10, '0);
    for (k = KIND_SPARE_FIRST; k != KIND_PUSH; k++) add_op(k, '1, '1);
    add_op(KIND_PUSH, '0, '0);
    add_op(KIND_READ_CUR, '0, '0);
    add_op(KIND_REWIND, '1, '1);
    add_op(KIND_OVERWRITE, '1, '1);
    add_op(KIND_READ_OLD, '0, '0);
    add_random_history(ring_ops.size() + RANDOM_OPS);

    wait (rst_n === 1'b1);
    @(posedge clk);
    for (i = 0; i < ring_ops.size(); i++) begin
      phase = i * 3 / ring_ops.size();
      idle_phase <= phase;
      sent_count <= i;
      idle_pct = (phase == 0) ? 30 : (phase == 1) ? 59 : 0;
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= ring_ops[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DefaultDepth + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[timestamped_history_ring_rewind] OK");
    end else begin
      $display("[timestamped_history_ring_rewind] ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned idle_pct;
    int unsigned hold_left;
    bit          pressure_done;
    out_stall <= 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!pressure_done && idle_phase == 2 && sent_count >= ring_ops.size() * 5 / 6) begin
        // hold off the output while the sender keeps offering
        pressure_done = 1'b1;
        for (hold_left = HOLD_CYCLES; hold_left != 0; hold_left--) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      idle_pct = (idle_phase == 0) ? 59 : (idle_phase == 1) ? 30 : 0;
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

endmodule
